### design/one_wire_master_assert.svh
// ---------------------------------------------------------------------------
// One-wire master assertion macros
// Checks compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ONE_WIRE_MASTER_ASSERT_SVH
`define ONE_WIRE_MASTER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, quiet during reset.
`define OWM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, quiet during reset.
`define OWM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OWM_ASSERT_IMP(label, ante, cons, msg)
`define OWM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### design/owm_pkg.sv
// ---------------------------------------------------------------------------
// One-wire master package
// Shared types, codes and constants of the one-wire bus master.
// ---------------------------------------------------------------------------
package owm_pkg;

  // Timer and configuration register width.
  localparam int CNT_W = 12;

  // Depth of the queue between the front and the engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Stream widths.
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  // Command codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } owm_op_t;

  // Bus sequencing phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_TAIL,
    PH_SLOT
  } owm_phase_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_LOW     = 3'd0,
    REG_ZERO_LOW      = 3'd1,
    REG_READ_SAMPLE   = 3'd2,
    REG_SLOT_TOTAL    = 3'd3,
    REG_RESET_LOW     = 3'd4,
    REG_PRESENCE_WAIT = 3'd5,
    REG_RESET_TAIL    = 3'd6
  } owm_reg_t;

  // Register values after reset.
  localparam logic [CNT_W-1:0] RST_SHORT_LOW     = 12'd6;
  localparam logic [CNT_W-1:0] RST_ZERO_LOW      = 12'd60;
  localparam logic [CNT_W-1:0] RST_READ_SAMPLE   = 12'd9;
  localparam logic [CNT_W-1:0] RST_SLOT_TOTAL    = 12'd70;
  localparam logic [CNT_W-1:0] RST_RESET_LOW     = 12'd480;
  localparam logic [CNT_W-1:0] RST_PRESENCE_WAIT = 12'd70;
  localparam logic [CNT_W-1:0] RST_RESET_TAIL    = 12'd410;

  // One classified tick as held in the queue.
  typedef struct packed {
    owm_op_t     op;
    logic        is_cmd;
    logic [7:0]  tx_byte;
    logic        line_level;
  } owm_item_t;

  // One result as held in the output register.
  typedef struct packed {
    logic        cmd_rejected;
    logic [7:0]  rx_byte;
    logic        presence;
    logic        done_res;
    logic        busy_res;
    logic        drive_low;
  } owm_res_t;

  // A timing below the given floor counts as the floor.
  function automatic logic [CNT_W-1:0] owm_floor(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] lo);
    owm_floor = (v < lo) ? lo : v;
  endfunction

endpackage

### design/owm_front.sv
// ---------------------------------------------------------------------------
// One-wire master front
// Accepts tick transfers, classifies the command and queues them.
// ---------------------------------------------------------------------------
module owm_front
  import owm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: tx_byte [7:0], line_level [8], zero fill [15:9]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: operation [1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  q_pop,
  output logic                  q_valid,
  output owm_item_t             q_item
);

  owm_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;
  logic                  push;
  owm_item_t             item_in;

  // Classify the incoming tick.
  always_comb begin
    item_in.op         = owm_op_t'(in_tuser);
    item_in.is_cmd     = (owm_op_t'(in_tuser) != OP_TICK);
    item_in.tx_byte    = in_tdata[7:0];
    item_in.line_level = in_tdata[8];
  end

  assign in_tready = (count_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

`include "one_wire_master_assert.svh"

  `OWM_ASSERT_IMP(a_count_bound, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue overfilled")
  `OWM_ASSERT_IMP(a_pop_nonempty, q_pop, count_r != '0, "pop from empty queue")
  `OWM_ASSERT_NXT(a_push_count, push && !q_pop, count_r == $past(count_r) + 1'b1,
                  "queue count missed a push")

endmodule

### design/owm_engine.sv
// ---------------------------------------------------------------------------
// One-wire master engine
// Runs the bus reset and bit slot timing one tick per queued item.
// ---------------------------------------------------------------------------
module owm_engine
  import owm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  owm_item_t              q_item,
  output logic                   q_pop,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CNT_W-1:0]       cfg_wdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: drive_low [0], busy_res [1], done_res [2], presence [3],
  //        rx_byte [11:4], cmd_rejected [12], zero fill [15:13]
  output logic [OUT_DATA_W-1:0]  out_tdata
);

  // Timing registers.
  logic [CNT_W-1:0] short_low_r, zero_low_r, read_sample_r, slot_total_r;
  logic [CNT_W-1:0] reset_low_r, presence_wait_r, reset_tail_r;

  // Sequencing state.
  owm_phase_t       phase_r, phase_nxt;
  owm_op_t          op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             pres_r, pres_nxt;
  logic [7:0]       last_r, last_nxt;
  logic             done_nxt;

  // Output register.
  logic             out_valid_r;
  owm_res_t         res_r, res_nxt;

  // Per-tick working values.
  logic             start;
  owm_phase_t       ph_cur;
  owm_op_t          op_cur;
  logic [7:0]       shift_cur;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] total, low_raw, low;
  logic [CNT_W:0]   at_sum;
  logic [CNT_W-1:0] at;
  logic [7:0]       shift_smp;
  logic             sample_hit;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_low_r     <= RST_SHORT_LOW;
      zero_low_r      <= RST_ZERO_LOW;
      read_sample_r   <= RST_READ_SAMPLE;
      slot_total_r    <= RST_SLOT_TOTAL;
      reset_low_r     <= RST_RESET_LOW;
      presence_wait_r <= RST_PRESENCE_WAIT;
      reset_tail_r    <= RST_RESET_TAIL;
    end else if (cfg_we) begin
      unique case (owm_reg_t'(cfg_addr))
        REG_SHORT_LOW:     short_low_r     <= cfg_wdata;
        REG_ZERO_LOW:      zero_low_r      <= cfg_wdata;
        REG_READ_SAMPLE:   read_sample_r   <= cfg_wdata;
        REG_SLOT_TOTAL:    slot_total_r    <= cfg_wdata;
        REG_RESET_LOW:     reset_low_r     <= cfg_wdata;
        REG_PRESENCE_WAIT: presence_wait_r <= cfg_wdata;
        REG_RESET_TAIL:    reset_tail_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A command from idle starts its operation on this same tick.
  assign start     = q_item.is_cmd && (phase_r == PH_IDLE);
  assign op_cur    = start ? q_item.op : op_r;
  assign shift_cur = start ? ((q_item.op == OP_WRITE) ? q_item.tx_byte : 8'h00) : shift_r;
  assign cnt1      = (start ? '0 : cnt_r) + 1'b1;

  always_comb begin
    if (!start) begin
      ph_cur = phase_r;
    end else if (q_item.op == OP_RESET) begin
      ph_cur = PH_RST_LOW;
    end else begin
      ph_cur = PH_SLOT;
    end
  end

  // Slot timing: low time clamped below the total, sample point clamped to it.
  assign total   = owm_floor(slot_total_r, CNT_W'(2));
  assign low_raw = (op_cur == OP_WRITE && !shift_cur[0]) ? owm_floor(zero_low_r, CNT_W'(1))
                                                         : owm_floor(short_low_r, CNT_W'(1));
  assign low     = (low_raw > total - 1'b1) ? total - 1'b1 : low_raw;
  assign at_sum  = {1'b0, low} + {1'b0, owm_floor(read_sample_r, CNT_W'(1))};
  assign at      = (at_sum > {1'b0, total}) ? total : at_sum[CNT_W-1:0];
  assign sample_hit = (op_cur == OP_READ) && (cnt1 == at);
  assign shift_smp  = sample_hit ? {q_item.line_level, shift_cur[7:1]} : shift_cur;

  // Next state of the sequencer.
  always_comb begin
    phase_nxt = phase_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pres_nxt  = pres_r;
    last_nxt  = last_r;
    done_nxt  = 1'b0;
    if (start) begin
      op_nxt    = q_item.op;
      cnt_nxt   = '0;
      bit_nxt   = '0;
      shift_nxt = shift_cur;
      phase_nxt = ph_cur;
    end
    unique case (ph_cur)
      PH_IDLE: ;
      PH_RST_LOW: begin
        cnt_nxt = cnt1;
        if (cnt1 >= owm_floor(reset_low_r, CNT_W'(1))) begin
          phase_nxt = PH_RST_WAIT;
          cnt_nxt   = '0;
        end
      end
      PH_RST_WAIT: begin
        cnt_nxt = cnt1;
        if (cnt1 >= owm_floor(presence_wait_r, CNT_W'(1))) begin
          pres_nxt = ~q_item.line_level;
          cnt_nxt  = '0;
          if (reset_tail_r == '0) begin
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_RST_TAIL;
          end
        end
      end
      PH_RST_TAIL: begin
        cnt_nxt = cnt1;
        if (cnt1 >= reset_tail_r) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end
      end
      PH_SLOT: begin
        cnt_nxt   = cnt1;
        shift_nxt = shift_smp;
        if (cnt1 >= total) begin
          if (op_cur == OP_WRITE) begin
            shift_nxt = {1'b0, shift_cur[7:1]};
          end
          cnt_nxt = '0;
          if (bit_r == 3'd7 && !start) begin
            if (op_cur == OP_READ) begin
              last_nxt = shift_smp;
            end
            bit_nxt   = '0;
            done_nxt  = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            bit_nxt = (start ? 3'd0 : bit_r) + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result of this tick.
  always_comb begin
    res_nxt.drive_low    = (ph_cur == PH_RST_LOW) || (ph_cur == PH_SLOT && cnt1 <= low);
    res_nxt.busy_res     = (ph_cur != PH_IDLE);
    res_nxt.done_res     = done_nxt;
    res_nxt.presence     = pres_nxt;
    res_nxt.rx_byte      = last_nxt;
    res_nxt.cmd_rejected = q_item.is_cmd && (phase_r != PH_IDLE);
  end

  // State advances only when a tick is taken from the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      op_r    <= OP_TICK;
      cnt_r   <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      pres_r  <= 1'b0;
      last_r  <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pres_r  <= pres_nxt;
      last_r  <= last_nxt;
    end
  end

  // Output register: loads on every pop, empties on a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(owm_res_t))'(0), res_r};

`include "one_wire_master_assert.svh"

  `OWM_ASSERT_IMP(a_bit_in_slot, bit_r != '0, phase_r == PH_SLOT,
                  "bit index set outside a slot")
  `OWM_ASSERT_NXT(a_done_idle, q_pop && done_nxt, phase_r == PH_IDLE,
                  "sequencer not idle after done")
  `OWM_ASSERT_IMP(a_drive_busy, out_valid_r && res_r.drive_low, res_r.busy_res,
                  "bus driven low while not busy")

endmodule

### design/one_wire_master.sv
// ---------------------------------------------------------------------------
// One-wire bus master
// Bus reset, byte write and byte read with programmable bit timing.
// ---------------------------------------------------------------------------
// Each input transfer is one timing tick: tuser carries the command (tick
// only, bus reset, write byte, read byte), tdata the byte to send and the
// sampled line level. Every tick yields exactly one output transfer holding
// the line drive, busy, done, presence, the last read byte and a flag for a
// command that arrived while busy and was dropped.
// A 2-entry queue sits between the input front and the timing engine, and
// the engine writes an output register. One tick is taken per cycle while
// out_tready does not hold the output register; a tick's result passes
// through the queue and then the output register. The engine's single-tick
// step (timer compare and slot decode) sets that rate.
// When out_tready is low the result is held, the engine stops, the queue
// fills and in_tready drops; no tick is lost or repeated.
// The user writes the timing registers through cfg_we/cfg_addr/cfg_wdata
// only while the block is idle; the block does not enforce it. A synchronous
// reset returns them to their default values, empties the queue and idles
// the sequencer.
module one_wire_master
  import owm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: tx_byte [7:0], line_level [8], zero fill [15:9]
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // tuser: operation [1:0]
  input  logic [IN_USER_W-1:0]   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: drive_low [0], busy_res [1], done_res [2], presence [3],
  //        rx_byte [11:4], cmd_rejected [12], zero fill [15:13]
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CNT_W-1:0]       cfg_wdata
);

  logic      q_valid;
  logic      q_pop;
  owm_item_t q_item;

  // Input front and tick queue.
  owm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // Timing engine and output register.
  owm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### dv/one_wire_master_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// One-wire bus master testbench
// Drives one tick per input transfer, predicts every tick's result from an
// internal model of the bus sequencer and compares each output transfer
// field by field. Covers the default timing, every command, zero and
// oversized timings, a long reset, commands that arrive while busy,
// long output backpressure and randomized traffic under several pacings.
// ---------------------------------------------------------------------------
module one_wire_master_test;
  import owm_pkg::*;

  localparam int NUM_TIMINGS    = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  // Timing register values after reset, in register index order.
  localparam logic [CNT_W-1:0] DEFAULT_TIMING [NUM_TIMINGS] =
    '{12'd6, 12'd60, 12'd9, 12'd70, 12'd480, 12'd70, 12'd410};

  // State of the bus sequencer as the testbench predicts it.
  typedef struct packed {
    logic [NUM_TIMINGS-1:0][CNT_W-1:0] timing;
    owm_phase_t                        phase;
    owm_op_t                           op;
    logic [CNT_W-1:0]                  ticks;
    logic [2:0]                        bit_idx;
    logic [7:0]                        shreg;
    logic                              present;
    logic [7:0]                        rx_last;
  } bus_model_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = REG_SHORT_LOW;
  logic [CNT_W-1:0]      cfg_wdata  = '0;

  bus_model_t bus;
  owm_res_t   pending_results [$];
  int         error_count  = 0;
  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         hold_asks    = 0;
  int         hold_seen    = 0;
  int         hold_left    = 0;
  int         quiet_cycles = 0;

  one_wire_master u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A timing register as the sequencer uses it: a value below lo counts as lo.
  function automatic logic [CNT_W-1:0] timing_of(input bus_model_t m, input owm_reg_t idx,
                                                 input logic [CNT_W-1:0] lo);
    timing_of = (m.timing[idx] < lo) ? lo : m.timing[idx];
  endfunction

  // Advances the sequencer by one tick and returns the result of that tick.
  function automatic owm_res_t step_bus(inout bus_model_t m, input owm_op_t cmd,
                                        input logic [7:0] tx, input logic line);
    owm_res_t         r;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] low;
    logic [CNT_W:0]   sample_at;
    r = '0;
    // A command starts only from idle; otherwise it is dropped and flagged.
    if (cmd != OP_TICK) begin
      if (m.phase != PH_IDLE) begin
        r.cmd_rejected = 1'b1;
      end else begin
        m.op      = cmd;
        m.ticks   = '0;
        m.bit_idx = '0;
        m.shreg   = (cmd == OP_WRITE) ? tx : 8'h00;
        m.phase   = (cmd == OP_RESET) ? PH_RST_LOW : PH_SLOT;
      end
    end
    if (m.phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      m.ticks    = m.ticks + 1'b1;
      case (m.phase)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          if (m.ticks >= timing_of(m, REG_RESET_LOW, 1)) begin
            m.phase = PH_RST_WAIT;
            m.ticks = '0;
          end
        end
        PH_RST_WAIT: begin
          if (m.ticks >= timing_of(m, REG_PRESENCE_WAIT, 1)) begin
            m.present = ~line;
            m.ticks   = '0;
            // With no tail the reset finishes on the presence sample.
            if (timing_of(m, REG_RESET_TAIL, 0) == 0) begin
              r.done_res = 1'b1;
              m.phase    = PH_IDLE;
            end else begin
              m.phase = PH_RST_TAIL;
            end
          end
        end
        PH_RST_TAIL: begin
          if (m.ticks >= timing_of(m, REG_RESET_TAIL, 0)) begin
            r.done_res = 1'b1;
            m.phase    = PH_IDLE;
            m.ticks    = '0;
          end
        end
        default: begin
          // Bit slot: low time cut so that every slot ends released.
          total = timing_of(m, REG_SLOT_TOTAL, 2);
          if (m.op == OP_WRITE && !m.shreg[0]) low = timing_of(m, REG_ZERO_LOW, 1);
          else low = timing_of(m, REG_SHORT_LOW, 1);
          if (low > total - 1'b1) low = total - 1'b1;
          r.drive_low = (m.ticks <= low);
          if (m.op == OP_READ) begin
            sample_at = {1'b0, low} + {1'b0, timing_of(m, REG_READ_SAMPLE, 1)};
            if (sample_at > {1'b0, total}) sample_at = {1'b0, total};
            if ({1'b0, m.ticks} == sample_at) m.shreg = {line, m.shreg[7:1]};
          end
          if (m.ticks >= total) begin
            if (m.op == OP_WRITE) m.shreg = m.shreg >> 1;
            m.ticks = '0;
            if (m.bit_idx == 3'd7) begin
              if (m.op == OP_READ) m.rx_last = m.shreg;
              m.bit_idx  = '0;
              r.done_res = 1'b1;
              m.phase    = PH_IDLE;
            end else begin
              m.bit_idx = m.bit_idx + 1'b1;
            end
          end
        end
      endcase
    end
    r.presence = m.present;
    r.rx_byte  = m.rx_last;
    return r;
  endfunction

  // True when a plain tick would end the running operation.
  function automatic logic ends_on_next_tick();
    bus_model_t probe;
    owm_res_t   r;
    probe = bus;
    r = step_bus(probe, OP_TICK, 8'h00, 1'b1);
    return r.done_res;
  endfunction

  // Offers one tick, waits for its transfer and records its expected result.
  task automatic send_tick(input owm_op_t cmd, input logic [7:0] tx, input logic line);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_DATA_W - 9){1'b0}}, line, tx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(step_bus(bus, cmd, tx, line));
  endtask

  // Runs one command to its end; the line follows pattern at the current bit.
  task automatic do_operation(input owm_op_t cmd, input logic [7:0] tx,
                              input logic [7:0] pattern);
    send_tick(cmd, tx, pattern[bus.bit_idx]);
    while (bus.phase != PH_IDLE) send_tick(OP_TICK, 8'($urandom), pattern[bus.bit_idx]);
  endtask

  // Lets the running operation end and every expected result arrive.
  task automatic finish_bus_activity();
    while (bus.phase != PH_IDLE) send_tick(OP_TICK, 8'($urandom), 1'($urandom));
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all seven timing registers while the block is idle.
  task automatic set_timings(input logic [CNT_W-1:0] short_low, zero_low, read_sample,
                             slot_total, reset_low, presence_wait, reset_tail);
    logic [CNT_W-1:0] vals [NUM_TIMINGS];
    vals = '{short_low, zero_low, read_sample, slot_total, reset_low, presence_wait,
             reset_tail};
    finish_bus_activity();
    for (int i = 0; i < NUM_TIMINGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= owm_reg_t'(i);
      cfg_wdata <= vals[i];
      bus.timing[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Result side: check each transfer, then choose the next ready value.
  always @(posedge clk) begin : result_side
    owm_res_t want;
    owm_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(owm_res_t)-1:0];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result %0h arrived with nothing expected", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("presence", want.presence, got.presence);
        check_field("rx_byte", want.rx_byte, got.rx_byte);
        check_field("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
        check_field("zero fill", 0, out_tdata[OUT_DATA_W-1:$bits(owm_res_t)]);
      end
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset timing values, a byte write with both slot kinds.
  task automatic test_default_timing();
    send_tick(OP_TICK, 8'hFF, 1'b1);
    send_tick(OP_TICK, 8'h00, 1'b0);
    do_operation(OP_WRITE, 8'hA6, 8'h00);
  endtask

  // Every command with short, ordinary timings.
  task automatic test_operations();
    set_timings(2, 5, 1, 7, 3, 2, 2);
    idle_pct  = 33;
    stall_pct = 33;
    do_operation(OP_WRITE, 8'h00, 8'h00);
    do_operation(OP_WRITE, 8'hFF, 8'hFF);
    do_operation(OP_READ, 8'h00, 8'hFF);
    do_operation(OP_READ, 8'hFF, 8'h96);
    do_operation(OP_RESET, 8'h00, 8'hFF);
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // All timings zero: each counts as its floor and the reset has no tail.
  task automatic test_zero_timings();
    set_timings(0, 0, 0, 0, 0, 0, 0);
    do_operation(OP_RESET, 8'h00, 8'h00);
    do_operation(OP_WRITE, 8'h5A, 8'h00);
    do_operation(OP_READ, 8'h00, 8'hA5);
  endtask

  // Low times and read sample beyond the slot are cut; a slot of one is two.
  task automatic test_long_low_cut();
    set_timings(4095, 4095, 4095, 3, 1, 1, 1);
    do_operation(OP_WRITE, 8'h0F, 8'h00);
    do_operation(OP_READ, 8'h00, 8'h6C);
    set_timings(4095, 4095, 4095, 1, 1, 1, 0);
    do_operation(OP_WRITE, 8'hF0, 8'h00);
    do_operation(OP_READ, 8'h00, 8'h81);
  endtask

  // Commands during an operation and on its final tick are dropped.
  task automatic test_command_while_busy();
    set_timings(1, 3, 1, 5, 2, 1, 1);
    send_tick(OP_WRITE, 8'hC3, 1'b1);
    send_tick(OP_TICK, 8'h00, 1'b1);
    send_tick(OP_RESET, 8'h00, 1'b0);
    send_tick(OP_READ, 8'hFF, 1'b0);
    send_tick(OP_WRITE, 8'h3C, 1'b1);
    while (!ends_on_next_tick()) send_tick(OP_TICK, 8'h00, 1'b1);
    send_tick(OP_READ, 8'h00, 1'b1);
    send_tick(OP_READ, 8'h00, 1'b1);
    while (!ends_on_next_tick()) send_tick(OP_TICK, 8'h00, 1'b0);
    send_tick(OP_RESET, 8'h00, 1'b0);
    send_tick(OP_RESET, 8'h00, 1'b0);
    finish_bus_activity();
  endtask

  // A long reset: extended low pulse, late presence sample and a tail.
  task automatic test_long_timing();
    set_timings(1, 4095, 4095, 4095, 120, 60, 20);
    do_operation(OP_RESET, 8'h00, 8'hFF);
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    set_timings(1, 2, 1, 4, 2, 1, 1);
    hold_asks <= hold_asks + 1;
    do_operation(OP_WRITE, 8'h3C, 8'h00);
    do_operation(OP_READ, 8'h00, 8'hC9);
  endtask

  // Mostly complete commands with random content, some dropped commands.
  task automatic run_random_traffic(input int unsigned n_ticks);
    owm_op_t     cmd;
    int unsigned pick;
    for (int unsigned i = 0; i < n_ticks; i++) begin
      pick = $urandom_range(99);
      if (bus.phase == PH_IDLE)
        cmd = (pick < 8) ? OP_TICK : owm_op_t'($urandom_range(3, 1));
      else if (pick < 4 || (pick < 40 && ends_on_next_tick()))
        cmd = owm_op_t'($urandom_range(3, 1));
      else
        cmd = OP_TICK;
      send_tick(cmd, 8'($urandom), 1'($urandom));
    end
  endtask

  // Random timings and traffic under each pacing in turn.
  task automatic test_random();
    for (int k = 0; k < 8; k++) begin
      set_timings(CNT_W'($urandom_range(5)), CNT_W'($urandom_range(9)),
                  CNT_W'($urandom_range(6)), CNT_W'($urandom_range(10)),
                  CNT_W'($urandom_range(8)), CNT_W'($urandom_range(6)),
                  CNT_W'($urandom_range(5)));
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 80; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 80; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      run_random_traffic(20);
    end
  endtask

  initial begin
    bus         = '0;
    bus.phase   = PH_IDLE;
    bus.op      = OP_TICK;
    for (int i = 0; i < NUM_TIMINGS; i++) bus.timing[i] = DEFAULT_TIMING[i];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_timing();
    test_operations();
    test_zero_timings();
    test_long_low_cut();
    test_command_while_busy();
    test_long_timing();
    test_backpressure();
    test_random();

    // Drain: everything expected must arrive before the final verdict.
    finish_bus_activity();
    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
